### src/upml_flux_field_update_defines.svh
// Assertion macros shared by the UPML flux update block.
`ifndef UPML_FLUX_FIELD_UPDATE_DEFINES_SVH
`define UPML_FLUX_FIELD_UPDATE_DEFINES_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define UPML_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upml: same-cycle check failed");

// Next-cycle implication, checked on every rising clk outside reset.
`define UPML_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upml: next-cycle check failed");

`endif

### src/upml_pkg.sv
// Package: sizes, types and helpers of the UPML flux update block.
package upml_pkg;

    localparam int CELLS       = 4096;
    localparam int CELL_W      = 12;
    localparam int CELL_AW     = $clog2(CELLS);
    localparam int STORE_DEPTH = 3 * CELLS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int DATA_W     = 32;                  // Q16.16 fields and fluxes
    localparam int COEF_W     = 32;                  // Q2.30 coefficients
    localparam int PROD_W     = DATA_W + COEF_W;
    localparam int FRAC_SHIFT = 30;
    localparam int TRUNC_W    = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = TRUNC_W + 1;

    localparam int OP_W        = 2;
    localparam int COMP_W      = 2;
    localparam int OP_POST_BIT = 0;                  // 1: post update, 0: pre update
    localparam int OP_CURR_BIT = 1;                  // 1: current store, 0: voltage store

    localparam logic [COMP_W-1:0] COMP_NONE = 2'd3;  // no store entry

    typedef struct packed {
        logic                active;
        logic [STORE_AW-1:0] addr;
    } clr_status_t;

    typedef struct packed {
        logic [DATA_W-1:0] new_flux;
        logic [DATA_W-1:0] result;
        logic              clip;
    } upd_result_t;

    // Store entry of a component/cell pair; cells wrap modulo CELLS.
    function automatic logic [STORE_AW-1:0] store_addr(
        input logic [COMP_W-1:0] comp,
        input logic [CELL_W-1:0] cell_idx
    );
        store_addr = STORE_AW'(comp) * STORE_AW'(CELLS) + STORE_AW'(cell_idx[CELL_AW-1:0]);
    endfunction

endpackage

### src/upml_flux_field_update.sv
// Top level: pipelined UPML auxiliary-flux update with two flux stores.
//
//  channel | handshake             | fields
//  --------+-----------------------+------------------------------------------------------------
//  item    | item_valid/item_stall | opcode cell_index component field_value coef_scale coef_flux
//  result  | res_valid/res_stall   | field_out saturated
//
//  An accepted word passes stage 1, stage 2 and the result register; one word per cycle
//  while item_stall is low. A word in stage 1 behind a pre update of the same store entry
//  in stage 2 waits there (that pre update's new flux is not ready until stage 2 ends).
//  After reset the stores are cleared, one entry per cycle over all 12288 entries,
//  with item_stall high.
//  res_stall freezes the result register; the stages behind it fill their bubbles first.
module upml_flux_field_update (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [upml_pkg::OP_W-1:0]           opcode,
    input  logic [upml_pkg::CELL_W-1:0]         cell_index,
    input  logic [upml_pkg::COMP_W-1:0]         component,
    input  logic signed [upml_pkg::DATA_W-1:0]  field_value,
    input  logic signed [upml_pkg::COEF_W-1:0]  coef_scale,
    input  logic signed [upml_pkg::COEF_W-1:0]  coef_flux,

    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [upml_pkg::DATA_W-1:0]  field_out,
    output logic                                saturated
);

`include "upml_flux_field_update_defines.svh"

    localparam int AW = upml_pkg::STORE_AW;
    localparam int DW = upml_pkg::DATA_W;
    localparam int CW = upml_pkg::COEF_W;
    localparam int PW = upml_pkg::PROD_W;

    // ---------------------------------------------------------------
    // clearing pass
    // ---------------------------------------------------------------
    upml_pkg::clr_status_t clr;

    upml_clear u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (clr)
    );

    // ---------------------------------------------------------------
    // pipeline registers
    // ---------------------------------------------------------------
    // stage 1: accepted word; store read in flight
    logic                            s1_valid_reg;
    logic [upml_pkg::OP_W-1:0]       s1_op_reg;
    logic                            s1_ok_reg;
    logic [AW-1:0]                   s1_addr_reg;
    logic signed [DW-1:0]            s1_field_reg;
    logic signed [CW-1:0]            s1_scale_reg;
    logic signed [CW-1:0]            s1_fcoef_reg;

    // stage 2: products and the flux that went into them
    logic                            s2_valid_reg;
    logic [upml_pkg::OP_W-1:0]       s2_op_reg;
    logic                            s2_ok_reg;
    logic [AW-1:0]                   s2_addr_reg;
    logic signed [DW-1:0]            s2_field_reg;
    logic signed [DW-1:0]            s2_flux_reg;
    logic signed [PW-1:0]            s2_prod_a_reg;
    logic signed [PW-1:0]            s2_prod_b_reg;

    // result register
    logic                            res_valid_reg;
    logic signed [DW-1:0]            field_out_reg;
    logic                            saturated_reg;

    // last item write into a store (a read-first RAM read issued alongside it returns the old data)
    logic                            lw_valid_reg;
    logic                            lw_curr_reg;
    logic [AW-1:0]                   lw_addr_reg;
    logic signed [DW-1:0]            lw_data_reg;

    // ---------------------------------------------------------------
    // flow control
    // ---------------------------------------------------------------
    logic item_accept;
    logic out_free;
    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic hazard;
    logic same_s2;
    logic same_lw;
    logic s1_curr;
    logic s2_curr;
    logic s2_post;

    assign s1_curr = s1_op_reg[upml_pkg::OP_CURR_BIT];
    assign s2_curr = s2_op_reg[upml_pkg::OP_CURR_BIT];
    assign s2_post = s2_op_reg[upml_pkg::OP_POST_BIT];

    assign same_s2 = s2_valid_reg && s2_ok_reg && s1_ok_reg
                     && (s2_curr == s1_curr) && (s2_addr_reg == s1_addr_reg);
    assign same_lw = lw_valid_reg && s1_ok_reg
                     && (lw_curr_reg == s1_curr) && (lw_addr_reg == s1_addr_reg);

    // a pre update in stage 2 has no new flux until its sum is done
    assign hazard = s1_valid_reg && same_s2 && !s2_post;

    assign out_free    = !res_valid_reg || !res_stall;
    assign s2_free     = !s2_valid_reg || out_free;
    assign s1_go       = s1_valid_reg && s2_free && !hazard;
    assign s1_free     = !s1_valid_reg || s1_go;
    assign item_stall  = clr.active || !s1_free;
    assign item_accept = item_valid && !item_stall;

    // ---------------------------------------------------------------
    // flux stores
    // ---------------------------------------------------------------
    upml_pkg::upd_result_t upd;

    logic          item_we;
    logic          volt_we;
    logic          curr_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] volt_rdata;
    logic [DW-1:0] curr_rdata;

    assign item_we   = s2_valid_reg && s2_ok_reg && out_free;
    assign volt_we   = clr.active || (item_we && !s2_curr);
    assign curr_we   = clr.active || (item_we && s2_curr);
    assign ram_waddr = clr.active ? clr.addr : s2_addr_reg;
    assign ram_wdata = clr.active ? '0 : upd.new_flux;

    // re-read every cycle so a waiting word sees all but the latest write
    assign ram_raddr = item_accept ? upml_pkg::store_addr(component, cell_index)
                                   : s1_addr_reg;

    upml_ram #(
        .WIDTH (DW),
        .DEPTH (upml_pkg::STORE_DEPTH)
    ) u_volt_ram (
        .clk   (clk),
        .we    (volt_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (volt_rdata)
    );

    upml_ram #(
        .WIDTH (DW),
        .DEPTH (upml_pkg::STORE_DEPTH)
    ) u_curr_ram (
        .clk   (clk),
        .we    (curr_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (curr_rdata)
    );

    // ---------------------------------------------------------------
    // stage 1: flux forwarding and both multiplies
    // ---------------------------------------------------------------
    logic signed [DW-1:0] flux_s1;
    logic signed [PW-1:0] prod_a;
    logic signed [PW-1:0] prod_b;

    always_comb
    begin
        if (!s1_ok_reg)
        begin
            flux_s1 = '0;                      // component 3: flux is zero
        end
        else if (same_s2)
        begin
            flux_s1 = s2_field_reg;            // post update stores the field
        end
        else if (same_lw)
        begin
            flux_s1 = lw_data_reg;
        end
        else
        begin
            flux_s1 = s1_curr ? curr_rdata : volt_rdata;
        end
    end

    assign prod_a = s1_scale_reg * s1_field_reg;
    assign prod_b = s1_fcoef_reg * flux_s1;

    // ---------------------------------------------------------------
    // stage 2: truncate, add, saturate
    // ---------------------------------------------------------------
    upml_update u_update (
        .post   (s2_post),
        .flux   (s2_flux_reg),
        .field  (s2_field_reg),
        .prod_a (s2_prod_a_reg),
        .prod_b (s2_prod_b_reg),
        .res    (upd)
    );

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= item_accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_go;
            end
            if (out_free)
            begin
                res_valid_reg <= s2_valid_reg;
            end
            lw_valid_reg <= item_we;
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_op_reg    <= opcode;
            s1_ok_reg    <= component != upml_pkg::COMP_NONE;
            s1_addr_reg  <= upml_pkg::store_addr(component, cell_index);
            s1_field_reg <= field_value;
            s1_scale_reg <= coef_scale;
            s1_fcoef_reg <= coef_flux;
        end
        if (s1_go)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_ok_reg     <= s1_ok_reg;
            s2_addr_reg   <= s1_addr_reg;
            s2_field_reg  <= s1_field_reg;
            s2_flux_reg   <= flux_s1;
            s2_prod_a_reg <= prod_a;
            s2_prod_b_reg <= prod_b;
        end
        if (s2_valid_reg && out_free)
        begin
            field_out_reg <= upd.result;
            saturated_reg <= upd.clip;
        end
        if (item_we)
        begin
            lw_curr_reg <= s2_curr;
            lw_addr_reg <= s2_addr_reg;
            lw_data_reg <= upd.new_flux;
        end
    end

    assign res_valid = res_valid_reg;
    assign field_out = field_out_reg;
    assign saturated = saturated_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // pipeline stays empty while the stores are being cleared
    `UPML_ASSERT_NOW(a_empty_in_clear, clr.active,
        !s1_valid_reg && !s2_valid_reg && !res_valid_reg && !lw_valid_reg)
    // a held word waits for a pre update ahead of it only while the result register is stalled
    `UPML_ASSERT_NEXT(a_hazard_once, hazard && out_free, !hazard)
    // a word leaving stage 1 always lands in stage 2
    `UPML_ASSERT_NEXT(a_s1_to_s2, s1_go, s2_valid_reg)

endmodule

### src/upml_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module upml_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/upml_clear.sv
// Post-reset clearing sequencer: walks every flux store entry once.
module upml_clear (
    input  logic                  clk,
    input  logic                  rst_n,
    output upml_pkg::clr_status_t status
);

    localparam logic [upml_pkg::STORE_AW-1:0] LAST_ADDR =
        upml_pkg::STORE_AW'(upml_pkg::STORE_DEPTH - 1);

    logic                          active_reg;
    logic [upml_pkg::STORE_AW-1:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            addr_reg   <= '0;
        end
        else if (active_reg)
        begin
            if (addr_reg == LAST_ADDR)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    assign status.active = active_reg;
    assign status.addr   = addr_reg;

endmodule

### src/upml_update.sv
// Truncate products, add, saturate and pick the new flux and the result.
module upml_update (
    input  logic                                  post,
    input  logic signed [upml_pkg::DATA_W-1:0]    flux,
    input  logic signed [upml_pkg::DATA_W-1:0]    field,
    input  logic signed [upml_pkg::PROD_W-1:0]    prod_a,
    input  logic signed [upml_pkg::PROD_W-1:0]    prod_b,
    output upml_pkg::upd_result_t                 res
);

    localparam int SW = upml_pkg::SUM_W;
    localparam int DW = upml_pkg::DATA_W;
    localparam int TW = upml_pkg::TRUNC_W;

    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    logic signed [TW-1:0] a_trunc;
    logic signed [TW-1:0] b_trunc;
    logic signed [SW-1:0] a_ext;
    logic signed [SW-1:0] b_ext;
    logic signed [SW-1:0] flux_ext;
    logic signed [SW-1:0] lhs;
    logic signed [SW-1:0] rhs;
    logic signed [SW-1:0] sum;
    logic                 clip_hi;
    logic                 clip_lo;
    logic [DW-1:0]        sat;

    // arithmetic shift right by 30 == floor toward minus infinity
    assign a_trunc  = prod_a[upml_pkg::PROD_W-1:upml_pkg::FRAC_SHIFT];
    assign b_trunc  = prod_b[upml_pkg::PROD_W-1:upml_pkg::FRAC_SHIFT];
    assign a_ext    = {{(SW-TW){a_trunc[TW-1]}}, a_trunc};
    assign b_ext    = {{(SW-TW){b_trunc[TW-1]}}, b_trunc};
    assign flux_ext = {{(SW-DW){flux[DW-1]}}, flux};

    // pre: scale*field - fcoef*flux; post: flux + scale*field
    assign lhs = post ? flux_ext : a_ext;
    assign rhs = post ? a_ext : -b_ext;
    assign sum = lhs + rhs;

    assign clip_hi = sum > SAT_MAX;
    assign clip_lo = sum < SAT_MIN;

    always_comb
    begin
        if (clip_hi)
        begin
            sat = SAT_MAX[DW-1:0];
        end
        else if (clip_lo)
        begin
            sat = SAT_MIN[DW-1:0];
        end
        else
        begin
            sat = sum[DW-1:0];
        end
    end

    assign res.new_flux = post ? field : sat;
    assign res.result   = post ? sat : flux;
    assign res.clip     = clip_hi | clip_lo;

endmodule
